// ===== design/sphere_triangle_subdivide_macros.svh =====
// Assertion macros used by the checker file.
`ifndef SPHERE_TRIANGLE_SUBDIVIDE_MACROS_SVH
`define SPHERE_TRIANGLE_SUBDIVIDE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STSD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stsd same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define STSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stsd next-cycle check failed");

`endif

// ===== design/stsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package stsd_pkg;

  // Coordinate format.
  localparam int COORD_W   = 16;
  localparam int FRAC_BITS = 14;

  // Unhalved midpoint sums need one extra bit.
  localparam int VEC_W  = COORD_W + 1;
  localparam int SQ_W   = 2 * VEC_W - 1;
  localparam int SUM_W  = SQ_W + 2;

  // Root search: one result bit per step.
  localparam int ROOT_W  = COORD_W;
  localparam int STEP_W  = $clog2(ROOT_W);
  localparam int R_SHIFT = 2 + 2 * FRAC_BITS;
  localparam int Y_SHIFT = 2 * (ROOT_W - 1);
  localparam int ACC_W   = SUM_W + Y_SHIFT + 3;

  localparam int NUM_VEC = 6;
  localparam int DATA_W  = 9 * COORD_W;
  localparam int CHILD_W = 2;

  // Child triangle codes.
  localparam logic [CHILD_W-1:0] CHILD_CENTER = 2'd0;
  localparam logic [CHILD_W-1:0] CHILD_A      = 2'd1;
  localparam logic [CHILD_W-1:0] CHILD_B      = 2'd2;
  localparam logic [CHILD_W-1:0] CHILD_C      = 2'd3;

  // Vector slots in a job.
  localparam logic [2:0] VI_A  = 3'd0;
  localparam logic [2:0] VI_B  = 3'd1;
  localparam logic [2:0] VI_C  = 3'd2;
  localparam logic [2:0] VI_AB = 3'd3;
  localparam logic [2:0] VI_BC = 3'd4;
  localparam logic [2:0] VI_CA = 3'd5;

  typedef logic [VEC_W-1:0]   comp_t;
  typedef comp_t [2:0]        vec_t;
  typedef vec_t [NUM_VEC-1:0] job_t;

  typedef logic [COORD_W-1:0]  coord_t;
  typedef coord_t [2:0]        nvec_t;
  typedef nvec_t [NUM_VEC-1:0] nres_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic load;
    logic step;
  } lane_ctl_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SQUARE,
    BK_LOAD,
    BK_RUN,
    BK_HOLD
  } bk_state_t;

  // Vector slot for a corner of a child triangle.
  function automatic logic [2:0] vec_sel(input logic [CHILD_W-1:0] child,
                                         input logic [1:0] corner);
    logic [2:0] p;
    logic [2:0] q;
    logic [2:0] r;
    case (child)
      CHILD_CENTER: begin
        p = VI_AB; q = VI_BC; r = VI_CA;
      end
      CHILD_A: begin
        p = VI_A; q = VI_AB; r = VI_CA;
      end
      CHILD_B: begin
        p = VI_B; q = VI_BC; r = VI_AB;
      end
      default: begin
        p = VI_C; q = VI_CA; r = VI_BC;
      end
    endcase
    case (corner)
      2'd0:    vec_sel = p;
      2'd1:    vec_sel = q;
      default: vec_sel = r;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== design/sphere_triangle_subdivide.sv =====
// An accepted triangle passes the queue, then square, load, root search and hold, before its first child.
// One triangle at a time runs the 16-step root search that the eighteen component lanes
// run in parallel, after square and load and before handoff; the queue takes new triangles meanwhile.
// Each triangle gives four child items on consecutive cycles when out_tready is high.
// Reset (rst_n low, synchronous) empties the queue and drops any item in flight.
`timescale 1ns / 1ps
`default_nettype none

module sphere_triangle_subdivide (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire [stsd_pkg::DATA_W-1:0]   in_tdata,    // a_x a_y a_z b_x b_y b_z c_x c_y c_z
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [stsd_pkg::DATA_W-1:0]  out_tdata,   // p_x p_y p_z q_x q_y q_z r_x r_y r_z
  output logic                         out_tlast,
  output logic [stsd_pkg::CHILD_W-1:0] out_tuser    // child
);
  import stsd_pkg::*;

  fifo_stat_t stat;
  logic       push;
  logic       pop;
  job_t       push_job;
  job_t       pop_job;

  stsd_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .stat      (stat),
    .push      (push),
    .job       (push_job)
  );

  stsd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .stat     (stat)
  );

  stsd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .stat       (stat),
    .pop_job    (pop_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// ===== design/stsd_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stsd_fifo (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     push,
  input  stsd_pkg::job_t          push_job,
  input  wire                     pop,
  output stsd_pkg::job_t          pop_job,
  output stsd_pkg::fifo_stat_t    stat
);
  import stsd_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  // Two-entry job queue between front and back.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  assign pop_job    = mem_r[rd_ptr_r];
  assign stat.full  = cnt_r[1];
  assign stat.empty = (cnt_r == 2'd0);

endmodule

`default_nettype wire

// ===== design/stsd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stsd_front (
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire [stsd_pkg::DATA_W-1:0]   in_tdata,
  input  stsd_pkg::fifo_stat_t         stat,
  output logic                         push,
  output stsd_pkg::job_t               job
);
  import stsd_pkg::*;

  vec_t a;
  vec_t b;
  vec_t c;

  // Unpack the corners and sign-extend each coordinate by one bit.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a[i] = {in_tdata[(0 + i) * COORD_W + COORD_W - 1],
              in_tdata[(0 + i) * COORD_W +: COORD_W]};
      b[i] = {in_tdata[(3 + i) * COORD_W + COORD_W - 1],
              in_tdata[(3 + i) * COORD_W +: COORD_W]};
      c[i] = {in_tdata[(6 + i) * COORD_W + COORD_W - 1],
              in_tdata[(6 + i) * COORD_W +: COORD_W]};
    end
  end

  // Corners and unhalved edge sums; scale drops out in normalization.
  always_comb begin
    job[VI_A] = a;
    job[VI_B] = b;
    job[VI_C] = c;
    for (int i = 0; i < 3; i++) begin
      job[VI_AB][i] = a[i] + b[i];
      job[VI_BC][i] = b[i] + c[i];
      job[VI_CA][i] = c[i] + a[i];
    end
  end

  assign in_tready = ~stat.full;
  assign push      = in_tvalid & in_tready;

endmodule

`default_nettype wire

// ===== design/stsd_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stsd_lane (
  input  wire                          clk,
  input  stsd_pkg::lane_ctl_t          ctl,
  input  wire [stsd_pkg::SQ_W-1:0]     mag2,
  input  wire [stsd_pkg::SUM_W-1:0]    s_sum,
  input  wire                          neg,
  output logic [stsd_pkg::COORD_W-1:0] res
);
  import stsd_pkg::*;

  logic [ACC_W-1:0]  r_r;
  logic [ACC_W-1:0]  p_r;
  logic [ACC_W-1:0]  x_r;
  logic [ACC_W-1:0]  y_r;
  logic [ROOT_W-1:0] q_r;
  logic              zero_r;
  logic              neg_r;

  logic [ACC_W-1:0]  cand;
  logic              ok;
  logic [ROOT_W:0]   q_inc;
  logic [ROOT_W-1:0] m;

  // Trial square: (q + bit)^2 * S, kept as running sum and cross term.
  assign cand = p_r + x_r + y_r;
  assign ok   = (cand <= r_r);

  // Largest q with q^2 * S <= 4 * mag^2 * U^2, one bit per step.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      r_r    <= ACC_W'(mag2) << R_SHIFT;
      y_r    <= ACC_W'(s_sum) << Y_SHIFT;
      x_r    <= '0;
      p_r    <= '0;
      q_r    <= '0;
      zero_r <= (s_sum == '0);
      neg_r  <= neg;
    end else if (ctl.step) begin
      if (ok) begin
        p_r <= cand;
      end
      x_r <= (x_r >> 1) + (ok ? y_r : '0);
      y_r <= y_r >> 2;
      q_r <= {q_r[ROOT_W-2:0], ok};
    end
  end

  // Rounded magnitude is (q + 1) / 2, then sign and clamp.
  assign q_inc = {1'b0, q_r} + 1'b1;
  assign m     = q_inc[ROOT_W:1];

  always_comb begin
    if (zero_r) begin
      res = '0;
    end else if (neg_r) begin
      res = ~m + 1'b1;
    end else if (m[ROOT_W-1]) begin
      res = {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      res = m;
    end
  end

endmodule

`default_nettype wire

// ===== design/stsd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stsd_back (
  input  wire                          clk,
  input  wire                          rst_n,
  input  stsd_pkg::fifo_stat_t         stat,
  input  stsd_pkg::job_t               pop_job,
  output logic                         pop,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [stsd_pkg::DATA_W-1:0]  out_tdata,   // p_x p_y p_z q_x q_y q_z r_x r_y r_z
  output logic                         out_tlast,
  output logic [stsd_pkg::CHILD_W-1:0] out_tuser    // child
);
  import stsd_pkg::*;

  bk_state_t         state_r;
  bk_state_t         state_nxt;
  logic [STEP_W-1:0] step_r;
  job_t              vec_r;
  logic [VEC_W-1:0]  mag_abs [NUM_VEC][3];
  logic [SQ_W-1:0]   mag2_r [NUM_VEC][3];
  logic [SUM_W-1:0]  s_sum [NUM_VEC];
  nres_t             lane_res;
  nres_t             res_r;
  logic              busy_r;
  logic [CHILD_W-1:0] beat_r;
  lane_ctl_t         lane_ctl;
  logic              emit_take;
  logic              load_res;

  // The emitter can take a new set when idle or on its final beat.
  assign emit_take = ~busy_r | (out_tready & (beat_r == CHILD_C));

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer next state and controls.
  always_comb begin
    state_nxt     = state_r;
    pop           = 1'b0;
    lane_ctl.load = 1'b0;
    lane_ctl.step = 1'b0;
    load_res      = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!stat.empty) begin
          pop       = 1'b1;
          state_nxt = BK_SQUARE;
        end
      end
      BK_SQUARE: begin
        state_nxt = BK_LOAD;
      end
      BK_LOAD: begin
        lane_ctl.load = 1'b1;
        state_nxt     = BK_RUN;
      end
      BK_RUN: begin
        lane_ctl.step = 1'b1;
        if (step_r == STEP_W'(ROOT_W - 1)) begin
          state_nxt = BK_HOLD;
        end
      end
      BK_HOLD: begin
        if (emit_take) begin
          load_res  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Step counter for the root search.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (lane_ctl.load) begin
      step_r <= '0;
    end else if (lane_ctl.step) begin
      step_r <= step_r + 1'b1;
    end
  end

  // Magnitude of every component at its own width; -65536 maps to 65536.
  always_comb begin
    for (int v = 0; v < NUM_VEC; v++) begin
      for (int i = 0; i < 3; i++) begin
        mag_abs[v][i] = vec_r[v][i][VEC_W-1] ? (~vec_r[v][i] + 1'b1) : vec_r[v][i];
      end
    end
  end

  // Job capture and squared magnitudes, one multiplier per component.
  always_ff @(posedge clk) begin
    if (pop) begin
      vec_r <= pop_job;
    end
    if (state_r == BK_SQUARE) begin
      for (int v = 0; v < NUM_VEC; v++) begin
        for (int i = 0; i < 3; i++) begin
          mag2_r[v][i] <= SQ_W'(mag_abs[v][i]) * SQ_W'(mag_abs[v][i]);
        end
      end
    end
  end

  // Squared length of each vector.
  always_comb begin
    for (int v = 0; v < NUM_VEC; v++) begin
      s_sum[v] = SUM_W'(mag2_r[v][0]) + SUM_W'(mag2_r[v][1]) + SUM_W'(mag2_r[v][2]);
    end
  end

  // One search lane per component of every vector.
  for (genvar gv = 0; gv < NUM_VEC; gv++) begin : g_vec
    for (genvar gc = 0; gc < 3; gc++) begin : g_comp
      stsd_lane u_lane (
        .clk   (clk),
        .ctl   (lane_ctl),
        .mag2  (mag2_r[gv][gc]),
        .s_sum (s_sum[gv]),
        .neg   (vec_r[gv][gc][VEC_W-1]),
        .res   (lane_res[gv][gc])
      );
    end
  end

  // Result buffer, so the lanes can start the next job during emission.
  always_ff @(posedge clk) begin
    if (load_res) begin
      res_r <= lane_res;
    end
  end

  // Emitter: four child triangles per job.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      beat_r <= CHILD_CENTER;
    end else if (load_res) begin
      busy_r <= 1'b1;
      beat_r <= CHILD_CENTER;
    end else if (busy_r && out_tready) begin
      beat_r <= beat_r + 1'b1;
      if (beat_r == CHILD_C) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = busy_r;
  assign out_tuser  = beat_r;
  assign out_tlast  = (beat_r == CHILD_C);
  assign out_tdata  = {res_r[vec_sel(beat_r, 2'd2)],
                       res_r[vec_sel(beat_r, 2'd1)],
                       res_r[vec_sel(beat_r, 2'd0)]};

endmodule

`default_nettype wire

// ===== design/stsd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "sphere_triangle_subdivide_macros.svh"

module stsd_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          out_tvalid,
  input wire                          out_tready,
  input wire [stsd_pkg::DATA_W-1:0]   out_tdata,
  input wire                          out_tlast,
  input wire [stsd_pkg::CHILD_W-1:0]  out_tuser
);
  import stsd_pkg::*;

  // The last item of a triangle is always the corner-c child.
  `STSD_ASSERT_NOW(a_last_is_c, clk, rst_n, out_tvalid, out_tlast == (out_tuser == CHILD_C))

  // Children of one triangle follow in order without gaps.
  `STSD_ASSERT_NEXT(a_child_seq, clk, rst_n, out_tvalid && out_tready && !out_tlast, out_tvalid && (out_tuser == CHILD_W'($past(out_tuser) + 1'b1)))

  // A stalled item stays offered.
  `STSD_ASSERT_NEXT(a_hold_valid, clk, rst_n, out_tvalid && !out_tready, out_tvalid)

  // A stalled item keeps its payload.
  `STSD_ASSERT_NEXT(a_hold_data, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tuser))

endmodule

bind sphere_triangle_subdivide stsd_checker u_stsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import stsd_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [DATA_W-1:0]  verts;
    logic [CHILD_W-1:0] child;
    logic               last;
  } child_tri_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  wire  in_tready;
  logic [DATA_W-1:0] in_tdata;
  wire  out_tvalid;
  logic out_tready;
  wire  [DATA_W-1:0] out_tdata;
  wire  out_tlast;
  wire  [CHILD_W-1:0] out_tuser;

  child_tri_t expected_tris[$];
  int mismatches;
  int idle_pct;
  int stall_pct;
  int quiet_cycles;

  sphere_triangle_subdivide DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Rounded |m| * 2^FRAC_BITS / sqrt(s), found by bisection, limited to 32768.
  function automatic longint unsigned unit_mag(longint unsigned m, longint unsigned s);
    logic [127:0] rhs;
    logic [127:0] lhs;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned t;
    rhs = 128'(4 * m * m) * 128'(64'd1 << (2 * FRAC_BITS));
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = 2 * mid - 1;
      lhs = 128'(t * t) * 128'(s);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // Scale a direction to unit length with saturation; zero stays zero.
  function automatic logic [3*COORD_W-1:0] to_unit(longint v[3]);
    longint unsigned mag[3];
    longint unsigned s;
    longint unsigned m;
    logic [3*COORD_W-1:0] r;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (v[i] < 0) ? -v[i] : v[i];
      s += mag[i] * mag[i];
    end
    for (int i = 0; i < 3; i++) begin
      if (s == 0) begin
        r[i*COORD_W +: COORD_W] = '0;
      end else begin
        m = unit_mag(mag[i], s);
        if (v[i] < 0) r[i*COORD_W +: COORD_W] = COORD_W'(-longint'(m));
        else r[i*COORD_W +: COORD_W] = COORD_W'((m > 32767) ? 32767 : m);
      end
    end
    return r;
  endfunction

  // Queue the four child triangles of one input triangle.
  task automatic predict_children(logic [DATA_W-1:0] tri_in);
    longint corner[3][3];
    longint side_sum[3];
    logic [3*COORD_W-1:0] nv[6];
    child_tri_t t;
    for (int k = 0; k < 3; k++)
      for (int i = 0; i < 3; i++)
        corner[k][i] = longint'($signed(tri_in[(3*k+i)*COORD_W +: COORD_W]));
    for (int k = 0; k < 3; k++) begin
      nv[k] = to_unit(corner[k]);
      for (int i = 0; i < 3; i++) side_sum[i] = corner[k][i] + corner[(k+1)%3][i];
      nv[3+k] = to_unit(side_sum);
    end
    // Slots: a, b, c, ab, bc, ca.
    t.verts = {nv[5], nv[4], nv[3]}; t.child = CHILD_CENTER; t.last = 1'b0;
    expected_tris.insert(expected_tris.size(), t);
    t.verts = {nv[5], nv[3], nv[0]}; t.child = CHILD_A;
    expected_tris.insert(expected_tris.size(), t);
    t.verts = {nv[3], nv[4], nv[1]}; t.child = CHILD_B;
    expected_tris.insert(expected_tris.size(), t);
    t.verts = {nv[4], nv[5], nv[2]}; t.child = CHILD_C; t.last = 1'b1;
    expected_tris.insert(expected_tris.size(), t);
  endtask

  // Send one triangle, with random idle cycles ahead of it.
  task automatic send_triangle(logic [DATA_W-1:0] tri_in);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= tri_in;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_children(tri_in);
  endtask

  function automatic logic [DATA_W-1:0] pack_tri(int a[9]);
    logic [DATA_W-1:0] d;
    for (int i = 0; i < 9; i++) d[i*COORD_W +: COORD_W] = COORD_W'(a[i]);
    return d;
  endfunction

  function automatic logic [DATA_W-1:0] random_tri();
    logic [DATA_W-1:0] d;
    for (int i = 0; i < 9; i++) d[i*COORD_W +: COORD_W] = COORD_W'($urandom);
    return d;
  endfunction

  // Unit-sphere triangles: small perturbations around unit axes.
  function automatic logic [DATA_W-1:0] sphere_tri();
    int a[9];
    for (int i = 0; i < 9; i++) a[i] = $urandom_range(6000) - 3000;
    a[0] += 16384; a[4] += 16384; a[8] += 16384;
    if ($urandom_range(1)) a[0] = -a[0];
    if ($urandom_range(1)) a[4] = -a[4];
    if ($urandom_range(1)) a[8] = -a[8];
    return pack_tri(a);
  endfunction

  task automatic test_directed();
    send_triangle(pack_tri('{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}));
    send_triangle(pack_tri('{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384}));
    // All-zero and opposite vertices give zero-length vectors.
    send_triangle(pack_tri('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
    send_triangle(pack_tri('{16384, 0, 0, -16384, 0, 0, 0, 16384, 0}));
    // Extremes of the coordinate range.
    send_triangle(pack_tri('{32767, 32767, 32767, -32768, -32768, -32768,
                             32767, -32768, 0}));
    send_triangle(pack_tri('{-32768, 0, 0, -32768, 0, 0, 32767, 0, 0}));
    send_triangle(pack_tri('{1, 0, 0, 0, -1, 0, 0, 0, 1}));
    send_triangle(pack_tri('{-1, -1, -1, 1, 1, 1, -32768, 32767, -1}));
    send_triangle(pack_tri('{0, 0, 1, 0, 0, 0, 0, -1, 0}));
    send_triangle(pack_tri('{9459, 9459, 9459, -9459, 9459, -9459, 9459, -9459, -9459}));
  endtask

  task automatic test_random();
    for (int n = 0; n < 150; n++) begin
      // A middle stretch runs with no idling on either side.
      idle_pct = (n >= 60 && n < 90) ? 0 : 25;
      stall_pct = idle_pct;
      send_triangle(($urandom_range(3) == 0) ? random_tri() : sphere_tri());
    end
    idle_pct = 25;
    stall_pct = 25;
  endtask

  // Result check and receiver stalls.
  always @(posedge clk) begin
    child_tri_t e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_tris.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected child triangle %h", out_tdata);
        end else begin
          e = expected_tris.pop_front();
          if (out_tdata !== e.verts || out_tuser !== e.child || out_tlast !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected %h child %0d last %0d, got %h child %0d last %0d",
                       e.verts, e.child, e.last, out_tdata, out_tuser, out_tlast);
          end
        end
      end
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog on cycles with no accepted item.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    mismatches = 0;
    quiet_cycles = 0;
    idle_pct = 25;
    stall_pct = 25;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    in_tvalid <= 1'b0;
    while (expected_tris.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_tris.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/stsd_pkg.sv
design/stsd_fifo.sv
design/stsd_front.sv
design/stsd_lane.sv
design/stsd_back.sv
design/sphere_triangle_subdivide.sv
design/stsd_checker.sv
tb/tb.sv
